// File: hw/rtl/obco_pkg.sv
// ----------------------------------------------------------------------------
// obco_pkg
// Shared types, constants and helpers for the oriented box corner overlap
// block.
// ----------------------------------------------------------------------------
package obco_pkg;

    // function codes of an input beat
    localparam logic [1:0] FN_LOAD_CLR  = 2'd0;
    localparam logic [1:0] FN_LOAD_KEEP = 2'd1;
    localparam logic [1:0] FN_TEST      = 2'd2;

    localparam logic signed [15:0] Q14_ONE = 16'sd16384;

    // shared multiplier operand and product widths
    localparam int MUL_AW = 34;
    localparam int MUL_BW = 32;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // serial divider width and split point of the mean corner
    localparam int DIV_W = 50;
    localparam int SPLIT = 24;

    typedef struct packed {
        logic       start;
        logic [2:0] den;
    } t_div_req;

    function automatic logic signed [15:0] clamp_axis(input logic signed [15:0] v);
        logic signed [15:0] r;
        r = v;
        if (v > Q14_ONE) begin
            r = Q14_ONE;
        end else if (v < -Q14_ONE) begin
            r = -Q14_ONE;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        r = 32'(v);
        if (v > 68'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -68'sd2147483648) begin
            r = 32'sh8000_0000;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/obco_mul.sv
// ----------------------------------------------------------------------------
// obco_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module obco_mul import obco_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_AW-1:0] i_a,
    input  logic signed [MUL_BW-1:0] i_b,
    output logic signed [MUL_PW-1:0] o_p
);

    logic signed [MUL_PW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// File: hw/rtl/obco_div.sv
// ----------------------------------------------------------------------------
// obco_div
// Bit-serial restoring divider, two lanes sharing one small divisor (1..4).
// ----------------------------------------------------------------------------
module obco_div import obco_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    input  logic [DIV_W-1:0] i_num_x,
    input  logic [DIV_W-1:0] i_num_y,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quo_x,
    output logic [DIV_W-1:0] o_quo_y
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [2:0]       r_den;
    logic [2:0]       r_rem_x, r_rem_y;
    logic [DIV_W-1:0] r_q_x, r_q_y;

    logic [3:0] n_trial_x, n_trial_y;
    logic       n_ge_x, n_ge_y;
    logic [2:0] n_rem_x, n_rem_y;

    always_comb begin
        n_trial_x = {r_rem_x, r_q_x[DIV_W-1]};
        n_trial_y = {r_rem_y, r_q_y[DIV_W-1]};
        n_ge_x    = n_trial_x >= {1'b0, r_den};
        n_ge_y    = n_trial_y >= {1'b0, r_den};
        n_rem_x   = n_ge_x ? 3'(n_trial_x - {1'b0, r_den}) : n_trial_x[2:0];
        n_rem_y   = n_ge_y ? 3'(n_trial_y - {1'b0, r_den}) : n_trial_y[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den   <= i_req.den;
            r_rem_x <= '0;
            r_rem_y <= '0;
            r_q_x   <= i_num_x;
            r_q_y   <= i_num_y;
        end else if (r_busy) begin
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_q_x   <= {r_q_x[DIV_W-2:0], n_ge_x};
            r_q_y   <= {r_q_y[DIV_W-2:0], n_ge_y};
        end
    end

    assign o_done  = r_done;
    assign o_quo_x = r_q_x;
    assign o_quo_y = r_q_y;

endmodule

// File: hw/rtl/oriented_box_corner_overlap.sv
// ----------------------------------------------------------------------------
// oriented_box_corner_overlap
// 2D oriented box corner penetration test, Q16.16 positions, Q1.14 axes.
// Load beats (func 0 and 1) never stall the input. A test beat (func 2)
// stalls it through S_MUL, S_CORNER, S_CHECK and S_OUT, on contact also
// through S_DIV, S_POST, S_ACC and S_FACE. The one shared 34x32 multiplier
// builds the 12 rotation products before the four corners are walked one
// per cycle and the 8 products of the back rotation after; the bit-serial
// divide of the inside corner sum by the inside count runs in 50 steps. The
// result sits in an output register, so a new beat is taken while it waits.
// ----------------------------------------------------------------------------
module oriented_box_corner_overlap import obco_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic signed [15:0] i_axis_cos,
    input  logic signed [15:0] i_axis_sin,
    input  logic [30:0]        i_half_width,
    input  logic [30:0]        i_half_height,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_hit,
    output logic [30:0]        o_depth,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic signed [31:0] o_contact_sum_x,
    output logic signed [31:0] o_contact_sum_y,
    output logic [7:0]         o_contact_count
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_CORNER, S_CHECK, S_DIV, S_POST, S_ACC, S_FACE, S_OUT
    } t_state;

    localparam logic [3:0] PRE_LAST  = 4'd12;
    localparam logic [3:0] POST_LAST = 4'd8;

    t_state r_state;
    logic [3:0] r_step;

    // reference box
    logic signed [31:0] r_rcx, r_rcy;
    logic signed [15:0] r_rc, r_rs;
    logic [30:0]        r_rhw, r_rhh;

    // accumulators
    logic [30:0]        r_best_d;
    logic signed [15:0] r_best_nx, r_best_ny;
    logic signed [31:0] r_sum_x, r_sum_y;
    logic [7:0]         r_count;

    // box under test
    logic signed [31:0] r_cx, r_cy;
    logic signed [15:0] r_bc, r_bs;
    logic [30:0]        r_hw, r_hh;

    // rotation terms
    logic signed [31:0] r_u, r_v;
    logic signed [63:0] r_hwu, r_hhv, r_hwv, r_hhu, r_p0, r_q0;

    // corner walk
    logic signed [63:0] r_minx, r_maxx, r_miny, r_maxy, r_acc_x, r_acc_y;
    logic [2:0]         r_inside;

    logic               r_neg_x, r_neg_y;
    logic signed [DIV_W:0] r_ax, r_ay;
    logic signed [67:0] r_num_x, r_num_y;
    logic               r_hit;

    // output register
    logic               r_out_valid;
    logic               r_o_hit;
    logic [30:0]        r_o_depth;
    logic signed [15:0] r_o_nx, r_o_ny;
    logic signed [31:0] r_o_sx, r_o_sy;
    logic [7:0]         r_o_cnt;

    logic in_acc, out_free;
    logic signed [MUL_AW-1:0] n_mul_a;
    logic signed [MUL_BW-1:0] n_mul_b;
    logic signed [MUL_PW-1:0] mul_p;
    logic signed [32:0] n_dcx, n_dcy;
    logic signed [63:0] n_ex, n_ey, n_px, n_py;
    logic               n_in_corner, n_contact;
    logic signed [63:0] n_vx, n_vy, n_ux, n_uy;
    t_div_req           n_div_req;
    logic               div_done;
    logic [DIV_W-1:0]   div_qx, div_qy;
    logic signed [DIV_W:0] n_qxs, n_qys;
    logic [3:0]         n_op;
    logic signed [67:0] n_prod_w, n_term;
    logic signed [67:0] n_tx, n_ty;
    logic signed [64:0] n_pen, n_q;
    logic [30:0]        n_qsat;
    logic               n_better;
    logic signed [15:0] n_fnx, n_fny;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign n_dcx = 33'(r_cx) - 33'(r_rcx);
    assign n_dcy = 33'(r_cy) - 33'(r_rcy);
    assign n_ex  = $signed({5'b0, r_rhw, 28'b0});
    assign n_ey  = $signed({5'b0, r_rhh, 28'b0});

    // multiplier operand select
    always_comb begin
        n_mul_a = '0;
        n_mul_b = '0;
        if (r_state == S_MUL) begin
            case (r_step)
                4'd0:  begin n_mul_a = MUL_AW'(r_bc);  n_mul_b = MUL_BW'(r_rc); end
                4'd1:  begin n_mul_a = MUL_AW'(r_bs);  n_mul_b = MUL_BW'(r_rs); end
                4'd2:  begin n_mul_a = MUL_AW'(r_bc);  n_mul_b = MUL_BW'(r_rs); end
                4'd3:  begin n_mul_a = MUL_AW'(r_bs);  n_mul_b = MUL_BW'(r_rc); end
                4'd4:  begin n_mul_a = MUL_AW'(r_hw);  n_mul_b = r_u; end
                4'd5:  begin n_mul_a = MUL_AW'(r_hh);  n_mul_b = r_v; end
                4'd6:  begin n_mul_a = MUL_AW'(r_hw);  n_mul_b = r_v; end
                4'd7:  begin n_mul_a = MUL_AW'(r_hh);  n_mul_b = r_u; end
                4'd8:  begin n_mul_a = MUL_AW'(n_dcx); n_mul_b = MUL_BW'(r_rc); end
                4'd9:  begin n_mul_a = MUL_AW'(n_dcy); n_mul_b = MUL_BW'(r_rs); end
                4'd10: begin n_mul_a = MUL_AW'(n_dcy); n_mul_b = MUL_BW'(r_rc); end
                4'd11: begin n_mul_a = MUL_AW'(n_dcx); n_mul_b = MUL_BW'(r_rs); end
                default: begin n_mul_a = '0; n_mul_b = '0; end
            endcase
        end else if (r_state == S_POST) begin
            // mean corner split into a signed high part and an unsigned low part
            case (r_step)
                4'd0: n_mul_a = MUL_AW'($signed(r_ax[DIV_W:SPLIT]));
                4'd1: n_mul_a = MUL_AW'(r_ax[SPLIT-1:0]);
                4'd2: n_mul_a = MUL_AW'($signed(r_ay[DIV_W:SPLIT]));
                4'd3: n_mul_a = MUL_AW'(r_ay[SPLIT-1:0]);
                4'd4: n_mul_a = MUL_AW'($signed(r_ax[DIV_W:SPLIT]));
                4'd5: n_mul_a = MUL_AW'(r_ax[SPLIT-1:0]);
                4'd6: n_mul_a = MUL_AW'($signed(r_ay[DIV_W:SPLIT]));
                4'd7: n_mul_a = MUL_AW'(r_ay[SPLIT-1:0]);
                default: n_mul_a = '0;
            endcase
            n_mul_b = (r_step == 4'd0 || r_step == 4'd1 || r_step == 4'd6 ||
                       r_step == 4'd7) ? MUL_BW'(r_rc) : MUL_BW'(r_rs);
        end
    end

    obco_mul u_mul (
        .i_clk (i_clk),
        .i_a   (n_mul_a),
        .i_b   (n_mul_b),
        .o_p   (mul_p)
    );

    // corner in the reference frame: step bit 0 picks +hw, bit 1 picks +hh
    always_comb begin
        n_px = (r_p0 <<< 14) + (r_step[0] ? r_hwu : -r_hwu)
             + (r_step[1] ? r_hhv : -r_hhv);
        n_py = (r_q0 <<< 14) + (r_step[0] ? -r_hwv : r_hwv)
             + (r_step[1] ? r_hhu : -r_hhu);
        n_in_corner = (n_px >= -n_ex) && (n_px <= n_ex) &&
                      (n_py >= -n_ey) && (n_py <= n_ey);
        n_contact = !(r_maxx <= -n_ex || r_minx >= n_ex ||
                      r_maxy <= -n_ey || r_miny >= n_ey) && (r_inside != 3'd0);
    end

    // floor division of a negative sum uses -floor((-v + n - 1) / n)
    always_comb begin
        n_vx = r_acc_x >>> 12;
        n_vy = r_acc_y >>> 12;
        n_ux = (n_vx < 0) ? (-n_vx + 64'(r_inside) - 64'sd1) : n_vx;
        n_uy = (n_vy < 0) ? (-n_vy + 64'(r_inside) - 64'sd1) : n_vy;
        n_div_req.start = (r_state == S_CHECK) && n_contact;
        n_div_req.den   = r_inside;
        n_qxs = $signed({1'b0, div_qx});
        n_qys = $signed({1'b0, div_qy});
    end

    obco_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_div_req),
        .i_num_x (DIV_W'(n_ux)),
        .i_num_y (DIV_W'(n_uy)),
        .o_done  (div_done),
        .o_quo_x (div_qx),
        .o_quo_y (div_qy)
    );

    always_comb begin
        n_op     = r_step - 4'd1;
        n_prod_w = 68'(mul_p);
        n_term   = n_op[0] ? n_prod_w : (n_prod_w <<< SPLIT);
        n_tx     = 68'(r_rcx) + (r_num_x >>> 14) + 68'(r_sum_x);
        n_ty     = 68'(r_rcy) + (r_num_y >>> 14) + 68'(r_sum_y);
    end

    // face penetrations, one per step
    always_comb begin
        case (r_step[1:0])
            2'd0: begin
                n_pen = 65'(n_ex) - 65'(r_minx);
                n_fnx = r_rc;
                n_fny = r_rs;
            end
            2'd1: begin
                n_pen = 65'(r_maxx) + 65'(n_ex);
                n_fnx = -r_rc;
                n_fny = -r_rs;
            end
            2'd2: begin
                n_pen = 65'(n_ey) - 65'(r_miny);
                n_fnx = -r_rs;
                n_fny = r_rc;
            end
            default: begin
                n_pen = 65'(r_maxy) + 65'(n_ey);
                n_fnx = r_rs;
                n_fny = -r_rc;
            end
        endcase
        n_q      = n_pen >>> 12;
        n_qsat   = (n_q > 65'sh7FFF_FFFF) ? 31'h7FFF_FFFF : n_q[30:0];
        n_better = (n_q > 0) && ((n_qsat < r_best_d) || (r_best_d == 31'd0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_rcx       <= '0;
            r_rcy       <= '0;
            r_rc        <= Q14_ONE;
            r_rs        <= '0;
            r_rhw       <= '0;
            r_rhh       <= '0;
            r_best_d    <= '0;
            r_best_nx   <= '0;
            r_best_ny   <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_func == FN_LOAD_CLR || i_func == FN_LOAD_KEEP) begin
                            r_rcx <= i_center_x;
                            r_rcy <= i_center_y;
                            r_rc  <= clamp_axis(i_axis_cos);
                            r_rs  <= clamp_axis(i_axis_sin);
                            r_rhw <= i_half_width;
                            r_rhh <= i_half_height;
                            if (i_func == FN_LOAD_CLR) begin
                                r_best_d  <= '0;
                                r_best_nx <= '0;
                                r_best_ny <= '0;
                                r_sum_x   <= '0;
                                r_sum_y   <= '0;
                                r_count   <= '0;
                            end
                        end else if (i_func == FN_TEST) begin
                            r_cx    <= i_center_x;
                            r_cy    <= i_center_y;
                            r_bc    <= clamp_axis(i_axis_cos);
                            r_bs    <= clamp_axis(i_axis_sin);
                            r_hw    <= i_half_width;
                            r_hh    <= i_half_height;
                            r_hit   <= 1'b0;
                            r_step  <= '0;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    // product of the previous step lands now
                    case (n_op)
                        4'd0:  r_u   <= 32'(mul_p);
                        4'd1:  r_u   <= r_u + 32'(mul_p);
                        4'd2:  r_v   <= 32'(mul_p);
                        4'd3:  r_v   <= r_v - 32'(mul_p);
                        4'd4:  r_hwu <= 64'(mul_p);
                        4'd5:  r_hhv <= 64'(mul_p);
                        4'd6:  r_hwv <= 64'(mul_p);
                        4'd7:  r_hhu <= 64'(mul_p);
                        4'd8:  r_p0  <= 64'(mul_p);
                        4'd9:  r_p0  <= r_p0 + 64'(mul_p);
                        4'd10: r_q0  <= 64'(mul_p);
                        4'd11: r_q0  <= r_q0 - 64'(mul_p);
                        default: ;
                    endcase
                    if (r_step == PRE_LAST) begin
                        r_step  <= '0;
                        r_state <= S_CORNER;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                S_CORNER: begin
                    if (r_step == 4'd0 || n_px < r_minx) r_minx <= n_px;
                    if (r_step == 4'd0 || n_px > r_maxx) r_maxx <= n_px;
                    if (r_step == 4'd0 || n_py < r_miny) r_miny <= n_py;
                    if (r_step == 4'd0 || n_py > r_maxy) r_maxy <= n_py;
                    if (r_step == 4'd0) begin
                        r_acc_x  <= n_in_corner ? n_px : '0;
                        r_acc_y  <= n_in_corner ? n_py : '0;
                        r_inside <= {2'b0, n_in_corner};
                    end else if (n_in_corner) begin
                        r_acc_x  <= r_acc_x + n_px;
                        r_acc_y  <= r_acc_y + n_py;
                        r_inside <= r_inside + 3'd1;
                    end
                    if (r_step == 4'd3) begin
                        r_step  <= '0;
                        r_state <= S_CHECK;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                S_CHECK: begin
                    r_neg_x <= n_vx < 0;
                    r_neg_y <= n_vy < 0;
                    r_state <= n_contact ? S_DIV : S_OUT;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_ax    <= r_neg_x ? -n_qxs : n_qxs;
                        r_ay    <= r_neg_y ? -n_qys : n_qys;
                        r_num_x <= '0;
                        r_num_y <= '0;
                        r_step  <= '0;
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    if (r_step != 4'd0) begin
                        if (!n_op[2]) begin
                            r_num_x <= (n_op[1]) ? r_num_x - n_term : r_num_x + n_term;
                        end else begin
                            r_num_y <= r_num_y + n_term;
                        end
                    end
                    if (r_step == POST_LAST) begin
                        r_state <= S_ACC;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                S_ACC: begin
                    r_sum_x <= sat32(n_tx);
                    r_sum_y <= sat32(n_ty);
                    if (r_count != 8'hFF) r_count <= r_count + 8'd1;
                    r_step  <= '0;
                    r_state <= S_FACE;
                end
                S_FACE: begin
                    if (n_better) begin
                        r_best_d  <= n_qsat;
                        r_best_nx <= n_fnx;
                        r_best_ny <= n_fny;
                        r_hit     <= 1'b1;
                    end
                    if (r_step == 4'd3) begin
                        r_state <= S_OUT;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result beat payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_o_hit   <= r_hit;
            r_o_depth <= r_best_d;
            r_o_nx    <= r_best_nx;
            r_o_ny    <= r_best_ny;
            r_o_sx    <= r_sum_x;
            r_o_sy    <= r_sum_y;
            r_o_cnt   <= r_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_o_hit;
    assign o_depth         = r_o_depth;
    assign o_normal_x      = r_o_nx;
    assign o_normal_y      = r_o_ny;
    assign o_contact_sum_x = r_o_sx;
    assign o_contact_sum_y = r_o_sy;
    assign o_contact_count = r_o_cnt;

    // contact count only drops on a clearing load
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count < $past(r_count))) |->
            $past(in_acc && i_func == FN_LOAD_CLR))
        else $error("contact count dropped without a clear");

    // kept depth moves only in the face pass or on a clear
    a_depth_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_best_d != $past(r_best_d))) |->
            ($past(r_state == S_FACE) || $past(in_acc && i_func == FN_LOAD_CLR)))
        else $error("kept depth changed outside the face pass");

    // a reported hit always carries a nonzero depth
    a_hit_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> (o_depth != 31'd0))
        else $error("hit reported with zero depth");

    // a new result only comes out of the output state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid)) |-> $past(r_state == S_OUT))
        else $error("result raised outside the output state");

endmodule

// File: tb/tb_oriented_box_corner_overlap.sv
// ----------------------------------------------------------------------------
// tb_oriented_box_corner_overlap
// Self-checking bench for the oriented box corner overlap block: a queue of
// directed and random beats feeds a clocked driver, a local predictor keeps
// its own copy of the reference box and accumulators, and a clocked monitor
// compares every output beat with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_oriented_box_corner_overlap import obco_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  N_RANDOM    = 600;
    localparam int  HOLD_CYCLES = 400;
    localparam int  TAIL_CYCLES = 200;

    typedef struct {
        logic [1:0]         func;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [15:0] cs;
        logic signed [15:0] sn;
        logic [30:0]        hw;
        logic [30:0]        hh;
        bit                 drain;
    } t_box_beat;

    typedef struct {
        logic               hit;
        logic [30:0]        depth;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic [7:0]         cnt;
    } t_contact;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_func = '0;
    logic signed [31:0] i_center_x = '0;
    logic signed [31:0] i_center_y = '0;
    logic signed [15:0] i_axis_cos = '0;
    logic signed [15:0] i_axis_sin = '0;
    logic [30:0]        i_half_width = '0;
    logic [30:0]        i_half_height = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b1;
    logic               o_hit;
    logic [30:0]        o_depth;
    logic signed [15:0] o_normal_x;
    logic signed [15:0] o_normal_y;
    logic signed [31:0] o_contact_sum_x;
    logic signed [31:0] o_contact_sum_y;
    logic [7:0]         o_contact_count;

    oriented_box_corner_overlap dut (.*);

    t_box_beat pending_beats[$];
    t_contact  expected_contacts[$];
    int        n_errors = 0;
    int        n_accepted = 0;
    int        cycle_cnt = 0;
    bit        beat_taken = 1'b0;
    bit        hold_done = 1'b0;
    int        hold_cnt = 0;

    // predictor state
    longint rcx, rcy, rcos, rsin, rhw, rhh;
    longint best_d, best_nx, best_ny, acc_sx, acc_sy;
    int     acc_cnt;

    initial forever #5 i_clk = ~i_clk;

    function automatic longint clamp_q14(longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    function automatic longint fdiv(longint v, longint d);
        if (v >= 0) return v / d;
        return -((-v + d - 1) / d);
    endfunction

    function automatic longint sat_s32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic bit improve_depth(longint pen, longint nx, longint ny);
        longint q;
        q = fdiv(pen, 4096);
        if (q > 64'sh7FFFFFFF) q = 64'sh7FFFFFFF;
        if (q > 0 && (q < best_d || best_d == 0)) begin
            best_d = q;
            best_nx = nx;
            best_ny = ny;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // returns 1 when the beat produces an output beat
    function automatic bit predict_contact(t_box_beat b, output t_contact r);
        longint cx, cy, bc, bs, hw, hh, ex, ey;
        longint minx, maxx, miny, maxy, accx, accy, n_in;
        longint lx, ly, dx, dy, px, py, ax, ay, wx, wy;
        bit hit;
        cx = b.cx; cy = b.cy;
        bc = clamp_q14(b.cs); bs = clamp_q14(b.sn);
        hw = b.hw; hh = b.hh;
        r = '{default: '0};
        if (b.func == FN_LOAD_CLR || b.func == FN_LOAD_KEEP) begin
            rcx = cx; rcy = cy; rcos = bc; rsin = bs; rhw = hw; rhh = hh;
            if (b.func == FN_LOAD_CLR) begin
                best_d = 0; best_nx = 0; best_ny = 0;
                acc_sx = 0; acc_sy = 0; acc_cnt = 0;
            end
            return 1'b0;
        end
        if (b.func != FN_TEST) return 1'b0;
        ex = rhw <<< 28;
        ey = rhh <<< 28;
        minx = 0; maxx = 0; miny = 0; maxy = 0;
        accx = 0; accy = 0; n_in = 0; hit = 1'b0;
        for (int k = 0; k < 4; k++) begin
            lx = k[0] ? hw : -hw;
            ly = k[1] ? hh : -hh;
            dx = (cx - rcx) * 16384 + lx * bc - ly * bs;
            dy = (cy - rcy) * 16384 + lx * bs + ly * bc;
            px = dx * rcos + dy * rsin;
            py = dy * rcos - dx * rsin;
            if (k == 0 || px < minx) minx = px;
            if (k == 0 || px > maxx) maxx = px;
            if (k == 0 || py < miny) miny = py;
            if (k == 0 || py > maxy) maxy = py;
            if (px >= -ex && px <= ex && py >= -ey && py <= ey) begin
                n_in++;
                accx += px;
                accy += py;
            end
        end
        if (!(maxx <= -ex || minx >= ex || maxy <= -ey || miny >= ey) && n_in > 0) begin
            ax = fdiv(accx, n_in * 4096);
            ay = fdiv(accy, n_in * 4096);
            wx = rcx + fdiv(ax * rcos - ay * rsin, 16384);
            wy = rcy + fdiv(ax * rsin + ay * rcos, 16384);
            acc_sx = sat_s32(acc_sx + wx);
            acc_sy = sat_s32(acc_sy + wy);
            if (acc_cnt < 255) acc_cnt++;
            if (improve_depth(ex - minx, rcos, rsin)) hit = 1'b1;
            if (improve_depth(maxx + ex, -rcos, -rsin)) hit = 1'b1;
            if (improve_depth(ey - miny, -rsin, rcos)) hit = 1'b1;
            if (improve_depth(maxy + ey, rsin, -rcos)) hit = 1'b1;
        end
        r.hit = hit;
        r.depth = 31'(best_d);
        r.nx = 16'(best_nx);
        r.ny = 16'(best_ny);
        r.sx = 32'(acc_sx);
        r.sy = 32'(acc_sy);
        r.cnt = 8'(acc_cnt);
        return 1'b1;
    endfunction

    task automatic queue_beat(logic [1:0] f, logic signed [31:0] cx, logic signed [31:0] cy,
                              logic signed [15:0] c, logic signed [15:0] s,
                              logic [30:0] hw, logic [30:0] hh, bit drain = 1'b0);
        t_box_beat b;
        b = '{func: f, cx: cx, cy: cy, cs: c, sn: s, hw: hw, hh: hh, drain: drain};
        pending_beats.push_back(b);
    endtask

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(0, 9))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'(int'($urandom_range(0, 65535)));     // may exceed range
            default: return 16'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // stimulus
    initial begin
        logic signed [31:0] gcx, gcy;
        logic [30:0] ghw, ghh;
        int sel;
        // default reference has zero extents: no contact
        queue_beat(FN_TEST, 0, 0, 16384, 0, 31'h100, 31'h100);
        queue_beat(FN_LOAD_CLR, 0, 0, 16384, 0, 31'h10_0000, 31'h8_0000);
        queue_beat(FN_TEST, 0, 0, 16384, 0, 31'h1000, 31'h1000);
        queue_beat(FN_TEST, 32'sh8_0000, 0, 0, 16384, 31'h4_0000, 31'h1_0000);
        queue_beat(FN_TEST, 32'sh1000, 32'sh2000, 16384, 0, 0, 0);     // point box
        queue_beat(FN_TEST, 32'sh7FFF_FFFF, 32'sh8000_0000, 16384, 0, 31'h10, 31'h10);
        queue_beat(FN_TEST, 0, 0, 16'sh7FFF, 16'sh8000, 31'h2000, 31'h3000);
        queue_beat(2'd3, 32'sh1234, 32'sh5678, 16384, 0, 31'h100, 31'h100);
        queue_beat(FN_TEST, 0, 0, 16384, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        queue_beat(FN_TEST, 32'sh0F_FFFF, 0, 16384, 0, 31'h1, 31'h1);  // tiny penetration
        queue_beat(FN_LOAD_KEEP, 32'sh7FFF_0000, 32'sh7FFF_0000, -16384, 0,
                   31'h7FFF_FFFF, 31'h7FFF_FFFF);
        for (int i = 0; i < 4; i++)
            queue_beat(FN_TEST, 32'sh7FFF_0000, 32'sh7FFF_0000, 16384, 0, 31'h100, 31'h100);
        queue_beat(FN_LOAD_KEEP, 32'sh8000_0000, 32'sh8000_0000, 0, -16384,
                   31'h4000_0000, 31'h4000_0000);
        for (int i = 0; i < 4; i++)
            queue_beat(FN_TEST, 32'sh8000_0000, 32'sh8000_0000, 0, 16384, 31'h100, 31'h200);
        queue_beat(FN_LOAD_CLR, 0, 0, 16'sh7FFF, 16'sh8001, 31'h20_0000, 31'h20_0000);
        queue_beat(FN_TEST, 0, 0, 11585, 11585, 31'h1_0000, 31'h1_0000, 1'b1);

        gcx = 0; gcy = 0; ghw = 31'h20_0000; ghh = 31'h20_0000;
        for (int i = 0; i < N_RANDOM; i++) begin
            sel = $urandom_range(0, 99);
            if (i == 300) begin
                gcx = $urandom; gcy = $urandom;
                ghw = $urandom_range(31'h1000, 31'h40_0000);
                ghh = $urandom_range(31'h1000, 31'h40_0000);
                queue_beat(FN_LOAD_CLR, gcx, gcy, rand_axis(), rand_axis(), ghw, ghh);
            end else if (sel < 8) begin
                // full-range noise on every field
                queue_beat(2'($urandom), $urandom, $urandom, 16'($urandom), 16'($urandom),
                           31'($urandom), 31'($urandom), i == 450);
            end else if (sel < 12) begin
                queue_beat(2'd3, $urandom, $urandom, 16'($urandom), 16'($urandom),
                           31'($urandom), 31'($urandom));
            end else if (sel < 20) begin
                gcx = gcx + 32'(int'($urandom_range(0, 32'h40_0000)) - 32'h20_0000);
                gcy = gcy + 32'(int'($urandom_range(0, 32'h40_0000)) - 32'h20_0000);
                ghw = $urandom_range(0, 31'h40_0000);
                ghh = $urandom_range(0, 31'h40_0000);
                queue_beat(FN_LOAD_KEEP, gcx, gcy, rand_axis(), rand_axis(), ghw, ghh);
            end else begin
                // test box near the reference, so that most of them touch it
                queue_beat(FN_TEST,
                           gcx + 32'(int'($urandom_range(0, 32'h60_0000)) - 32'h30_0000),
                           gcy + 32'(int'($urandom_range(0, 32'h60_0000)) - 32'h30_0000),
                           rand_axis(), rand_axis(),
                           $urandom_range(0, 31'h30_0000), $urandom_range(0, 31'h30_0000),
                           i == 450);
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_beats.size() == 0 && expected_contacts.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && expected_contacts.size() == 0) begin
            $display("** oriented_box_corner_overlap: PASSED **");
        end else begin
            $display("** oriented_box_corner_overlap: FAILED **");
        end
        $finish;
    end

    // predictor reset
    initial begin
        rcx = 0; rcy = 0; rcos = 16384; rsin = 0; rhw = 0; rhh = 0;
        best_d = 0; best_nx = 0; best_ny = 0; acc_sx = 0; acc_sy = 0; acc_cnt = 0;
    end

    function automatic int send_idle_pct();
        if (n_accepted < 200) return 34;
        if (n_accepted < 400) return 58;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (n_accepted < 200) return 58;
        if (n_accepted < 400) return 34;
        return 0;
    endfunction

    // input side: take accepted beats into the predictor
    always @(posedge i_clk) begin
        t_contact r;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (predict_contact(pending_beats[0], r)) expected_contacts.push_back(r);
            void'(pending_beats.pop_front());
            n_accepted <= n_accepted + 1;
            beat_taken <= 1'b1;
        end else begin
            beat_taken <= 1'b0;
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || beat_taken)) begin
            if (pending_beats.size() == 0 || $urandom_range(0, 99) < send_idle_pct() ||
                (pending_beats[0].drain && expected_contacts.size() != 0)) begin
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid    <= 1'b1;
                i_func        <= pending_beats[0].func;
                i_center_x    <= pending_beats[0].cx;
                i_center_y    <= pending_beats[0].cy;
                i_axis_cos    <= pending_beats[0].cs;
                i_axis_sin    <= pending_beats[0].sn;
                i_half_width  <= pending_beats[0].hw;
                i_half_height <= pending_beats[0].hh;
            end
        end
    end

    // receiver stall, with one long hold-off partway through
    always @(negedge i_clk) begin
        if (!hold_done && n_accepted >= 120) begin
            hold_done <= 1'b1;
            hold_cnt  <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct());
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_contact e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_contacts.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected output beat at cycle %0d", cycle_cnt);
            end else begin
                e = expected_contacts.pop_front();
                if (o_hit !== e.hit || o_depth !== e.depth || o_normal_x !== e.nx ||
                    o_normal_y !== e.ny || o_contact_sum_x !== e.sx ||
                    o_contact_sum_y !== e.sy || o_contact_count !== e.cnt) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("mismatch at cycle %0d", cycle_cnt);
                        $display("  exp hit %0d depth %h n (%0d,%0d) sum (%h,%h) cnt %0d",
                                 e.hit, e.depth, e.nx, e.ny, e.sx, e.sy, e.cnt);
                        $display("  got hit %0d depth %h n (%0d,%0d) sum (%h,%h) cnt %0d",
                                 o_hit, o_depth, o_normal_x, o_normal_y,
                                 o_contact_sum_x, o_contact_sum_y, o_contact_count);
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("** oriented_box_corner_overlap: FAILED **");
            $finish;
        end
    end

endmodule
